[design/fdss_pkg.sv]
// Shared constants and lookup functions for the four-digit seven-segment scanner.
`timescale 1ns / 1ps

package fdss_pkg;

    localparam int DIGIT_TICKS_DEFAULT = 5;

    localparam int NUMBER_W = 14;
    localparam int MS_W     = 16;
    localparam int DIGIT_W  = 4;
    localparam int POS_W    = 2;
    localparam int TICK_W   = 8;
    localparam int ROUND_W  = 12;
    localparam int SEG_W    = 8;
    localparam int EN_W     = 4;

    localparam logic [NUMBER_W-1:0] NUMBER_MAX     = 14'd9999;
    localparam logic [SEG_W-1:0]    SEG_ALL_OFF    = 8'hFF;
    localparam logic [EN_W-1:0]     ENABLE_ALL_OFF = 4'hF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [DIGIT_W-1:0] digit_t;

    function automatic logic [SEG_W-1:0] font_lookup(input digit_t d);
        logic [SEG_W-1:0] seg;
        unique case (d)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_ALL_OFF;
        endcase
        return seg;
    endfunction

    function automatic logic [EN_W-1:0] enable_lookup(input logic [POS_W-1:0] pos);
        logic [EN_W-1:0] en;
        unique case (pos)
            2'd0:    en = 4'h7;
            2'd1:    en = 4'hB;
            2'd2:    en = 4'hD;
            default: en = 4'hE;
        endcase
        return en;
    endfunction

endpackage

[design/four_digit_seven_segment_scanner_core.sv]
// Top level of the four-digit seven-segment scanner: decimal split pipeline and scan state.
//
// Input channel s_*: each transaction is either a load (tuser op = 0) carrying a number
// and a display time in milliseconds, or a one-millisecond tick (op = 1). Output channel
// m_*: every input transaction yields exactly one output transaction with the segment
// byte, the digit select nibble and the time-up flag as they stand after that item.
// The block passes items through six registered stages and a result register. The
// decimal split of the number and the division of the display time by twenty run on
// constant reciprocal multipliers, spread over the stages so that no path chains more
// than one product and a subtraction. An item reaches the output through stages 1 to 6
// and the result register, and one item is accepted in every cycle while the output is taken.
// Each stage holds its item when the stage after it is full, so the input keeps
// accepting until all stages are occupied behind a stalled output. The scan state is
// updated in the last stage, in item order.
// After reset all stages are empty, the display is blank (segments all off, no digit
// selected) and ticks change nothing until the first load.
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner_core #(
    parameter int DIGIT_TICKS = fdss_pkg::DIGIT_TICKS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // number[13:0], display_ms[29:14], zero[31:30]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // segments_n[7:0], digit_enable_n[11:8], time_up[12]
);

    import fdss_pkg::*;

    // Stage valid bits and ready chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    assign rdy7     = !m_tvalid || m_tready;
    assign rdy6     = !v6_reg || rdy7;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Stage 1: input register with saturation.
    logic                op1_reg;
    logic [NUMBER_W-1:0] n1_reg;
    logic [MS_W-1:0]     ms1_reg;
    logic [NUMBER_W-1:0] n_in;

    assign n_in = (s_tdata[13:0] > NUMBER_MAX) ? NUMBER_MAX : s_tdata[13:0];

    // Stage 2: reciprocal products for thousands and rounds.
    logic                op2_reg;
    logic [NUMBER_W-1:0] n2_reg;
    logic [26:0]         pth2_reg;
    logic [29:0]         prd2_reg;

    // Stage 3: thousands digit, remainder below 1000, rounds.
    logic          op3_reg;
    digit_t        th3_reg;
    logic [9:0]    r3_reg;
    logic [MS_W-1:0] rounds3_reg;
    digit_t        th_s3;
    logic [NUMBER_W-1:0] r_s3;
    logic [ROUND_W-1:0]  rounds_s3;

    assign th_s3     = pth2_reg[26:23];
    assign r_s3      = n2_reg - NUMBER_W'(th_s3) * NUMBER_W'(1000);
    assign rounds_s3 = prd2_reg[29:18];

    // Stage 4: hundreds product.
    logic            op4_reg;
    digit_t          th4_reg;
    logic [9:0]      r4_reg;
    logic [15:0]     phu4_reg;
    logic [MS_W-1:0] rounds4_reg;

    // Stage 5: hundreds digit, remainder below 100.
    logic            op5_reg;
    digit_t          th5_reg;
    digit_t          hu5_reg;
    logic [6:0]      r5_reg;
    logic [MS_W-1:0] rounds5_reg;
    digit_t          hu_s5;
    logic [9:0]      r_s5;

    assign hu_s5 = phu4_reg[15:12];
    assign r_s5  = r4_reg - 10'(hu_s5) * 10'd100;

    // Stage 6: tens product.
    logic            op6_reg;
    digit_t          th6_reg;
    digit_t          hu6_reg;
    logic [6:0]      r6_reg;
    logic [14:0]     pte6_reg;
    logic [MS_W-1:0] rounds6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
        begin
            op1_reg <= s_tuser[0];
            n1_reg  <= n_in;
            ms1_reg <= s_tdata[29:14];
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg  <= op1_reg;
            n2_reg   <= n1_reg;
            pth2_reg <= 27'(n1_reg) * 27'd8389;
            prd2_reg <= 30'(ms1_reg[15:2]) * 30'd52429;
        end
        if (rdy3 && v2_reg)
        begin
            op3_reg     <= op2_reg;
            th3_reg     <= th_s3;
            r3_reg      <= r_s3[9:0];
            rounds3_reg <= (rounds_s3 == '0) ? MS_W'(1) : MS_W'(rounds_s3);
        end
        if (rdy4 && v3_reg)
        begin
            op4_reg     <= op3_reg;
            th4_reg     <= th3_reg;
            r4_reg      <= r3_reg;
            phu4_reg    <= 16'(r3_reg) * 16'd41;
            rounds4_reg <= rounds3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            op5_reg     <= op4_reg;
            th5_reg     <= th4_reg;
            hu5_reg     <= hu_s5;
            r5_reg      <= r_s5[6:0];
            rounds5_reg <= rounds4_reg;
        end
        if (rdy6 && v5_reg)
        begin
            op6_reg     <= op5_reg;
            th6_reg     <= th5_reg;
            hu6_reg     <= hu5_reg;
            r6_reg      <= r5_reg;
            pte6_reg    <= 15'(r5_reg) * 15'd205;
            rounds6_reg <= rounds5_reg;
        end
    end

    // Stage 7: scan state update and result register.
    digit_t            digit_reg [4];
    digit_t            digit_next [4];
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [TICK_W-1:0] tid_reg, tid_next;
    logic [MS_W-1:0]   left_reg, left_next;
    logic              showing_reg, showing_next;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg, out_data_next;
    digit_t            te_s7;
    digit_t            un_s7;
    logic [6:0]        un_wide;
    logic [TICK_W:0]   tid_inc;
    logic [POS_W-1:0]  pos_inc;
    logic [SEG_W-1:0]  seg_next;
    logic [EN_W-1:0]   en_next;
    logic              up_next;

    assign te_s7   = pte6_reg[14:11];
    assign un_wide = r6_reg - 7'(te_s7) * 7'd10;
    assign un_s7   = un_wide[3:0];
    assign tid_inc = {1'b0, tid_reg} + 9'd1;
    assign pos_inc = pos_reg + 2'd1;

    always_comb
    begin
        digit_next   = digit_reg;
        pos_next     = pos_reg;
        tid_next     = tid_reg;
        left_next    = left_reg;
        showing_next = showing_reg;
        if (op6_reg == OP_LOAD)
        begin
            digit_next[0] = th6_reg;
            digit_next[1] = hu6_reg;
            digit_next[2] = te_s7;
            digit_next[3] = un_s7;
            pos_next      = '0;
            tid_next      = '0;
            left_next     = rounds6_reg;
            showing_next  = 1'b1;
        end
        else if (showing_reg)
        begin
            if (tid_inc >= (TICK_W+1)'(DIGIT_TICKS))
            begin
                tid_next = '0;
                pos_next = pos_inc;
                if (pos_inc == '0 && left_reg != '0)
                begin
                    left_next = left_reg - MS_W'(1);
                end
            end
            else
            begin
                tid_next = tid_inc[TICK_W-1:0];
            end
        end

        if (showing_next)
        begin
            seg_next = font_lookup(digit_next[pos_next]);
            en_next  = enable_lookup(pos_next);
            up_next  = (left_next == '0);
        end
        else
        begin
            seg_next = SEG_ALL_OFF;
            en_next  = ENABLE_ALL_OFF;
            up_next  = 1'b0;
        end
        out_data_next = {3'b000, up_next, en_next, seg_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                digit_reg[i] <= '0;
            end
            pos_reg       <= '0;
            tid_reg       <= '0;
            left_reg      <= '0;
            showing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (rdy7)
        begin
            out_valid_reg <= v6_reg;
            if (v6_reg)
            begin
                digit_reg   <= digit_next;
                pos_reg     <= pos_next;
                tid_reg     <= tid_next;
                left_reg    <= left_next;
                showing_reg <= showing_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy7 && v6_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A blank digit select always comes with all segments dark.
    a_blank_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[11:8] == ENABLE_ALL_OFF) |-> (m_tdata[7:0] == SEG_ALL_OFF))
        else $error("digit select blank while segments lit");

    // The time-up flag on a pending result matches the round counter behind it.
    a_time_up_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |-> (left_reg == '0 && showing_reg))
        else $error("time_up reported with rounds remaining");

    // The per-digit tick counter never reaches the dwell length.
    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tid_reg < TICK_W'(DIGIT_TICKS)))
        else $error("tick counter out of range");

    // A result that waits is never replaced under a stall.
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_data_reg) && $stable(left_reg)))
        else $error("result or state changed while output stalled");

endmodule
